// ===== sv/csvt_pkg.sv =====
// Shared types, constants and helper functions for the CSV byte tokenizer.
`default_nettype none
package csvt_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] DELIM_RESET = 8'h2C;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             field_end;
      logic             row_end;
      logic             header_row;
      logic [CNT_W-1:0] column_count;
      logic             column_mismatch;
      logic             empty_input;
   } rec_type;

   // one queue entry: all results of one item (one or two)
   typedef struct packed {
      logic    two;
      rec_type r0;
      rec_type r1;
   } entry_type;

   typedef struct packed {
      logic             in_quotes;
      logic             quote_pending;
      logic             line_started;
      logic [CNT_W-1:0] field_counter;
   } line_type;

   typedef struct packed {
      line_type s;
      logic     emit;
      rec_type  r;
   } take_type;

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v >= CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : v + CNT_W'(1);
   endfunction

   // ordinary byte: anything but a newline or an arriving carriage return, plus a held carriage return
   function automatic take_type take_byte(line_type s, logic [7:0] b,
                                          logic [7:0] delim, logic hdr_seen);
      take_type t;
      logic     done;
      t = '0;
      t.s = s;
      t.s.line_started = 1'b1;
      t.r.header_row = !hdr_seen;
      done = 1'b0;
      if (s.quote_pending) begin
         t.s.quote_pending = 1'b0;
         if (b == CH_QUOTE) begin
            t.emit = 1'b1;
            t.r.out_byte = CH_QUOTE;
            t.r.byte_valid = 1'b1;
            done = 1'b1;
         end else begin
            t.s.in_quotes = 1'b0;
         end
      end
      if (!done) begin
         if (b == CH_QUOTE) begin
            if (t.s.in_quotes) begin
               t.s.quote_pending = 1'b1;
            end else begin
               t.s.in_quotes = 1'b1;
            end
         end else if (b == delim && !t.s.in_quotes) begin
            t.emit = 1'b1;
            t.r.field_end = 1'b1;
            t.s.field_counter = sat_inc(s.field_counter);
         end else begin
            t.emit = 1'b1;
            t.r.out_byte = b;
            t.r.byte_valid = 1'b1;
         end
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== sv/csvt_front.sv =====
// Front end: accepts bytes, runs the quote/line state and builds result entries.
`default_nettype none
module csvt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [7:0]          csr_delimiter,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_end_of_input,
   input  wire logic                q_full,
   output logic                     q_push,
   output csvt_pkg::entry_type      q_entry
);

   logic [7:0]                  delimiter_ff;
   csvt_pkg::line_type          line_ff, line_in;
   logic                        cr_pending_ff, cr_pending_in;
   logic                        header_seen_ff, header_seen_in;
   logic [csvt_pkg::CNT_W-1:0]  header_columns_ff, header_columns_in;

   logic                        accept;
   logic                        emit_in;
   csvt_pkg::entry_type         entry_in;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && emit_in;
   assign q_entry   = entry_in;

   always_comb begin
      csvt_pkg::take_type         t0;
      csvt_pkg::take_type         t1;
      csvt_pkg::line_type         st;
      csvt_pkg::rec_type          fin;
      logic [csvt_pkg::CNT_W-1:0] cnt;
      logic                       has_line;
      logic                       fin_emit;

      t0 = '0;
      t1 = '0;
      st = line_ff;
      fin_emit = 1'b0;
      has_line = 1'b0;
      line_in = line_ff;
      cr_pending_in = cr_pending_ff;
      header_seen_in = header_seen_ff;
      header_columns_in = header_columns_ff;
      entry_in = '0;

      cnt = csvt_pkg::sat_inc(line_ff.field_counter);
      fin = '0;
      fin.field_end = 1'b1;
      fin.row_end = 1'b1;
      fin.header_row = !header_seen_ff;
      fin.column_count = cnt;
      fin.column_mismatch = header_seen_ff && (cnt != header_columns_ff);

      if (req_end_of_input) begin
         has_line = header_seen_ff ? line_ff.line_started
                                   : (line_ff.line_started || cr_pending_ff);
         if (!header_seen_ff && !has_line) begin
            fin_emit = 1'b1;
            entry_in.r0.empty_input = 1'b1;
         end else if (has_line) begin
            fin_emit = 1'b1;
            entry_in.r0 = fin;
         end
         line_in = '0;
         cr_pending_in = 1'b0;
         header_seen_in = 1'b0;
         header_columns_in = '0;
      end else if (req_data_byte == csvt_pkg::CH_LF) begin
         if (!header_seen_ff || line_ff.line_started) begin
            fin_emit = 1'b1;
            entry_in.r0 = fin;
            if (!header_seen_ff) begin
               header_seen_in = 1'b1;
               header_columns_in = cnt;
            end
         end
         line_in = '0;
         cr_pending_in = 1'b0;
      end else begin
         if (cr_pending_ff) begin
            t0 = csvt_pkg::take_byte(st, csvt_pkg::CH_CR, delimiter_ff, header_seen_ff);
            st = t0.s;
            cr_pending_in = 1'b0;
         end
         if (req_data_byte == csvt_pkg::CH_CR) begin
            if (st.quote_pending) begin
               st.quote_pending = 1'b0;
               st.in_quotes = 1'b0;
            end
            cr_pending_in = 1'b1;
         end else begin
            t1 = csvt_pkg::take_byte(st, req_data_byte, delimiter_ff, header_seen_ff);
            st = t1.s;
         end
         line_in = st;
         if (t0.emit) begin
            entry_in.r0 = t0.r;
            if (t1.emit) begin
               entry_in.r1 = t1.r;
               entry_in.two = 1'b1;
            end
         end else if (t1.emit) begin
            entry_in.r0 = t1.r;
         end
      end
      emit_in = fin_emit || t0.emit || t1.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= csvt_pkg::DELIM_RESET;
         line_ff <= '0;
         cr_pending_ff <= 1'b0;
         header_seen_ff <= 1'b0;
         header_columns_ff <= '0;
      end else begin
         if (csr_valid) begin
            delimiter_ff <= csr_delimiter;
         end
         if (accept) begin
            line_ff <= line_in;
            cr_pending_ff <= cr_pending_in;
            header_seen_ff <= header_seen_in;
            header_columns_ff <= header_columns_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/csvt_queue.sv =====
// Small register queue of result entries between front and back.
`default_nettype none
module csvt_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire csvt_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output csvt_pkg::entry_type      head
);

   csvt_pkg::entry_type              mem_ff [csvt_pkg::QDEPTH];
   logic [csvt_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [csvt_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [csvt_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_pop;

   assign full      = (count_ff == csvt_pkg::QCNT_W'(csvt_pkg::QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == csvt_pkg::QPTR_W'(csvt_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + csvt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == csvt_pkg::QPTR_W'(csvt_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + csvt_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + csvt_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - csvt_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= csvt_pkg::QCNT_W'(csvt_pkg::QDEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule
`default_nettype wire

// ===== sv/csvt_back.sv =====
// Back end: drains queue entries to the output register, one result per unstalled cycle.
`default_nettype none
module csvt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_not_empty,
   input  wire csvt_pkg::entry_type q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output csvt_pkg::rec_type        rsp_rec,
   output logic                     rsp_last
);

   logic                 valid_ff, valid_in;
   csvt_pkg::rec_type    out_ff, out_in;
   logic                 last_ff, last_in;
   logic                 hold_valid_ff, hold_valid_in;
   csvt_pkg::rec_type    hold_ff, hold_in;
   logic                 free;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_rec   = out_ff;
   assign rsp_last  = last_ff;

   always_comb begin
      valid_in = valid_ff;
      out_in = out_ff;
      last_in = last_ff;
      hold_valid_in = hold_valid_ff;
      hold_in = hold_ff;
      q_pop = 1'b0;
      if (free) begin
         if (hold_valid_ff) begin
            valid_in = 1'b1;
            out_in = hold_ff;
            last_in = 1'b1;
            hold_valid_in = 1'b0;
         end else if (q_not_empty) begin
            q_pop = 1'b1;
            valid_in = 1'b1;
            out_in = q_head.r0;
            last_in = !q_head.two;
            hold_valid_in = q_head.two;
            hold_in = q_head.r1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      out_ff <= out_in;
      last_ff <= last_in;
      hold_ff <= hold_in;
   end

   a_hold_needs_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> valid_ff)
      else $error("second result held without first on output");

   a_not_last_has_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> hold_valid_ff)
      else $error("non-final result without a following one");

endmodule
`default_nettype wire

// ===== sv/csv_byte_tokenizer.sv =====
// Top level of the CSV byte tokenizer.
// Takes one text byte (or an end-of-input mark) per cycle and emits content
// bytes with field-end and row-end marks, header/row field counts and a
// mismatch flag. An item is taken every cycle while the four-entry result
// queue has room. Most items give zero or one result; a held carriage return
// followed by a byte other than a newline, carriage return or quote gives two,
// and the output register drains one result per cycle while not stalled.
// The delimiter register resets to ','.
`default_nettype none
module csv_byte_tokenizer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [7:0]                   csr_delimiter,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_end_of_input,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_byte_valid,
   output logic                              rsp_field_end,
   output logic                              rsp_row_end,
   output logic                              rsp_header_row,
   output logic [csvt_pkg::CNT_W-1:0]        rsp_column_count,
   output logic                              rsp_column_mismatch,
   output logic                              rsp_empty_input,
   output logic                              rsp_last_result
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_not_empty;
   csvt_pkg::entry_type    q_entry;
   csvt_pkg::entry_type    q_head;
   csvt_pkg::rec_type      rec;

   csvt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_delimiter    (csr_delimiter),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   csvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   csvt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_rec     (rec),
      .rsp_last    (rsp_last_result)
   );

   assign rsp_out_byte        = rec.out_byte;
   assign rsp_byte_valid      = rec.byte_valid;
   assign rsp_field_end       = rec.field_end;
   assign rsp_row_end         = rec.row_end;
   assign rsp_header_row      = rec.header_row;
   assign rsp_column_count    = rec.column_count;
   assign rsp_column_mismatch = rec.column_mismatch;
   assign rsp_empty_input     = rec.empty_input;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for csv_byte_tokenizer: directed and random byte streams.
module testbench;

   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic [7:0]                 out_byte;
      logic                       byte_valid;
      logic                       field_end;
      logic                       row_end;
      logic                       header_row;
      logic [csvt_pkg::CNT_W-1:0] column_count;
      logic                       column_mismatch;
      logic                       empty_input;
      logic                       last_result;
   } token_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [7:0]                 csr_delimiter;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_data_byte;
   logic                       req_end_of_input;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_byte_valid;
   logic                       rsp_field_end;
   logic                       rsp_row_end;
   logic                       rsp_header_row;
   logic [csvt_pkg::CNT_W-1:0] rsp_column_count;
   logic                       rsp_column_mismatch;
   logic                       rsp_empty_input;
   logic                       rsp_last_result;

   // tokenizer state as predicted
   logic [7:0]                 tk_delim;
   logic                       tk_in_quotes;
   logic                       tk_quote_pend;
   logic                       tk_cr_pend;
   logic                       tk_line_started;
   logic                       tk_header_seen;
   logic [csvt_pkg::CNT_W-1:0] tk_fields;
   logic [csvt_pkg::CNT_W-1:0] tk_header_cols;

   token_type   expected_tokens[$];
   token_type   new_tokens[$];
   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned mismatch_count;
   int unsigned burst_left;
   int unsigned cycles;

   csv_byte_tokenizer dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_delimiter       (csr_delimiter),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_input    (req_end_of_input),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_field_end       (rsp_field_end),
      .rsp_row_end         (rsp_row_end),
      .rsp_header_row      (rsp_header_row),
      .rsp_column_count    (rsp_column_count),
      .rsp_column_mismatch (rsp_column_mismatch),
      .rsp_empty_input     (rsp_empty_input),
      .rsp_last_result     (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------- prediction ----------------

   function automatic logic [csvt_pkg::CNT_W-1:0] bump(
         input logic [csvt_pkg::CNT_W-1:0] v);
      return (v >= csvt_pkg::CNT_W'(csvt_pkg::MAX_COLUMNS))
             ? csvt_pkg::CNT_W'(csvt_pkg::MAX_COLUMNS) : v + csvt_pkg::CNT_W'(1);
   endfunction

   task automatic add_token(input logic [7:0] b, input logic valid, fend, rend, hdr,
                            input logic [csvt_pkg::CNT_W-1:0] count,
                            input logic mis, empty);
      token_type t;
      t.out_byte        = b;
      t.byte_valid      = valid;
      t.field_end       = fend;
      t.row_end         = rend;
      t.header_row      = hdr;
      t.column_count    = count;
      t.column_mismatch = mis;
      t.empty_input     = empty;
      t.last_result     = 1'b0;
      new_tokens = {new_tokens, t};
   endtask

   task automatic take_text_byte(input logic [7:0] b);
      tk_line_started = 1'b1;
      if (tk_quote_pend) begin
         tk_quote_pend = 1'b0;
         if (b == csvt_pkg::CH_QUOTE) begin
            add_token(csvt_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0, !tk_header_seen, '0,
                      1'b0, 1'b0);
            return;
         end
         tk_in_quotes = 1'b0;
      end
      if (b == csvt_pkg::CH_QUOTE) begin
         if (tk_in_quotes) begin
            tk_quote_pend = 1'b1;
         end else begin
            tk_in_quotes = 1'b1;
         end
      end else if (b == tk_delim && !tk_in_quotes) begin
         add_token(8'h00, 1'b0, 1'b1, 1'b0, !tk_header_seen, '0, 1'b0, 1'b0);
         tk_fields = bump(tk_fields);
      end else begin
         add_token(b, 1'b1, 1'b0, 1'b0, !tk_header_seen, '0, 1'b0, 1'b0);
      end
   endtask

   task automatic close_line(input logic has_line);
      logic [csvt_pkg::CNT_W-1:0] count;
      count = bump(tk_fields);
      if (has_line) begin
         if (!tk_header_seen) begin
            add_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, count, 1'b0, 1'b0);
            tk_header_cols = count;
            tk_header_seen = 1'b1;
         end else begin
            add_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, count, count != tk_header_cols, 1'b0);
         end
      end
      tk_in_quotes    = 1'b0;
      tk_quote_pend   = 1'b0;
      tk_cr_pend      = 1'b0;
      tk_line_started = 1'b0;
      tk_fields       = '0;
   endtask

   task automatic clear_stream();
      tk_in_quotes    = 1'b0;
      tk_quote_pend   = 1'b0;
      tk_cr_pend      = 1'b0;
      tk_line_started = 1'b0;
      tk_header_seen  = 1'b0;
      tk_fields       = '0;
      tk_header_cols  = '0;
   endtask

   task automatic predict_tokens(input logic [7:0] b, input logic eoi);
      logic has_line;
      new_tokens.delete();
      if (eoi) begin
         has_line = tk_header_seen ? tk_line_started : (tk_line_started || tk_cr_pend);
         if (!tk_header_seen && !has_line) begin
            add_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
         end else begin
            close_line(has_line);
         end
         clear_stream();
      end else if (b == csvt_pkg::CH_LF) begin
         close_line(!tk_header_seen || tk_line_started);
      end else begin
         if (tk_cr_pend) begin
            tk_cr_pend = 1'b0;
            take_text_byte(csvt_pkg::CH_CR);
         end
         if (b == csvt_pkg::CH_CR) begin
            if (tk_quote_pend) begin
               tk_quote_pend = 1'b0;
               tk_in_quotes  = 1'b0;
            end
            tk_cr_pend = 1'b1;
         end else begin
            take_text_byte(b);
         end
      end
      if (new_tokens.size() > 0) begin
         new_tokens[new_tokens.size() - 1].last_result = 1'b1;
      end
      foreach (new_tokens[i]) begin
         expected_tokens = {expected_tokens, new_tokens[i]};
      end
   endtask

   // ---------------- drivers ----------------

   task automatic send_item(input logic [7:0] b, input logic eoi);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(b, eoi);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_tokens.size() != 0) @(posedge clock);
      // items without results may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delimiter(input logic [7:0] d);
      wait_drained();
      csr_valid     <= 1'b1;
      csr_delimiter <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tk_delim = d;
   endtask

   initial begin
      stall_mode_type mode;
      int unsigned    span;
      int unsigned    phase;
      rsp_stall <= 1'b0;
      phase = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            phase++;
            case (mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= (phase % 5) < 2;
               end
            endcase
         end
      end
   end

   // ---------------- checking ----------------

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("ERROR: %s", msg);
      end
   endtask

   function automatic string show_token(input token_type t);
      return $sformatf("byte %h bv %b fe %b re %b hdr %b cnt %0d mis %b empty %b last %b",
                       t.out_byte, t.byte_valid, t.field_end, t.row_end, t.header_row,
                       t.column_count, t.column_mismatch, t.empty_input, t.last_result);
   endfunction

   always @(posedge clock) begin
      token_type want;
      token_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_byte        = rsp_out_byte;
         got.byte_valid      = rsp_byte_valid;
         got.field_end       = rsp_field_end;
         got.row_end         = rsp_row_end;
         got.header_row      = rsp_header_row;
         got.column_count    = rsp_column_count;
         got.column_mismatch = rsp_column_mismatch;
         got.empty_input     = rsp_empty_input;
         got.last_result     = rsp_last_result;
         if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("result %0d with no item pending", results_checked));
         end else begin
            want = expected_tokens.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("result %0d: got %s; want %s", results_checked,
                                         show_token(got), show_token(want)));
            end
         end
         results_checked++;
      end
   end

   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("csv_byte_tokenizer test failed");
      $finish;
   end

   // ---------------- tests ----------------

   task automatic test_special_cases();
      send_item(8'hFF, 1'b1);                   // empty stream
      send_item(csvt_pkg::CH_LF, 1'b0);         // empty header line
      send_item(csvt_pkg::CH_LF, 1'b0);         // empty data line, skipped
      send_item("a", 1'b0);
      send_item(",", 1'b0);
      send_item(csvt_pkg::CH_QUOTE, 1'b0);
      send_item("x", 1'b0);
      send_item(csvt_pkg::CH_QUOTE, 1'b0);      // doubled quote
      send_item(csvt_pkg::CH_QUOTE, 1'b0);
      send_item("y", 1'b0);
      send_item(csvt_pkg::CH_QUOTE, 1'b0);
      send_item(csvt_pkg::CH_CR, 1'b0);         // CRLF
      send_item(csvt_pkg::CH_LF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(csvt_pkg::CH_CR, 1'b0);         // CR before an ordinary byte
      send_item(8'hFF, 1'b0);
      send_item(csvt_pkg::CH_LF, 1'b0);
      send_item(csvt_pkg::CH_QUOTE, 1'b0);
      send_item("q", 1'b0);
      send_item(csvt_pkg::CH_LF, 1'b0);         // newline inside quotes
      send_item(csvt_pkg::CH_QUOTE, 1'b0);
      send_item("z", 1'b0);
      send_item(csvt_pkg::CH_QUOTE, 1'b0);
      send_item(csvt_pkg::CH_LF, 1'b0);         // quote pending at line end
      send_item(8'h00, 1'b1);                   // nothing to flush
      send_item(csvt_pkg::CH_CR, 1'b0);
      send_item(8'h55, 1'b1);                   // lone CR still makes a header
      send_item("b", 1'b0);
      send_item(8'hAA, 1'b1);
   endtask

   task automatic test_delimiter_values();
      logic [7:0] picks[$];
      picks = {csvt_pkg::CH_CR, csvt_pkg::CH_QUOTE, csvt_pkg::CH_LF, 8'h00, 8'hFF};
      foreach (picks[i]) begin
         write_delimiter(picks[i]);
         send_item(csvt_pkg::CH_CR, 1'b0);
         send_item("a", 1'b0);
         send_item(csvt_pkg::CH_CR, 1'b0);
         send_item(picks[i], 1'b0);
         send_item(csvt_pkg::CH_CR, 1'b0);
         send_item(csvt_pkg::CH_LF, 1'b0);
         send_item(picks[i], 1'b0);
         send_item(csvt_pkg::CH_QUOTE, 1'b0);
         send_item(picks[i], 1'b0);
         send_item(csvt_pkg::CH_QUOTE, 1'b0);
         send_item(picks[i], 1'b0);
         send_item(csvt_pkg::CH_LF, 1'b0);
         send_item(8'h00, 1'b0);
         send_item(8'hFF, 1'b0);
         send_item(picks[i], 1'b0);
         send_item(8'h00, 1'b1);
      end
      write_delimiter(csvt_pkg::DELIM_RESET);
   endtask

   task automatic test_column_saturation();
      int unsigned row;
      int unsigned n;
      // header saturates; first data row saturates to a match, second falls one short
      for (row = 0; row < 3; row++) begin
         n = (row == 0) ? csvt_pkg::MAX_COLUMNS + 2 : csvt_pkg::MAX_COLUMNS - row;
         repeat (n) send_item(",", 1'b0);
         send_item(csvt_pkg::CH_LF, 1'b0);
      end
      send_item(8'h00, 1'b1);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_CR ||
                 b == csvt_pkg::CH_LF || b == tk_delim);
      return b;
   endfunction

   task automatic send_field();
      int unsigned kind;
      int unsigned pick;
      kind = $urandom_range(0, 9);
      if (kind >= 1 && kind <= 5) begin
         repeat ($urandom_range(1, 6)) send_item(plain_byte(), 1'b0);
      end else if (kind > 5) begin
         send_item(csvt_pkg::CH_QUOTE, 1'b0);
         repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               send_item(plain_byte(), 1'b0);
            end else if (pick < 77) begin
               send_item(csvt_pkg::CH_QUOTE, 1'b0);
               send_item(csvt_pkg::CH_QUOTE, 1'b0);
            end else if (pick < 87) begin
               send_item(tk_delim, 1'b0);
            end else if (pick < 97) begin
               send_item(csvt_pkg::CH_CR, 1'b0);
            end else begin
               send_item(csvt_pkg::CH_LF, 1'b0);
            end
         end
         send_item(csvt_pkg::CH_QUOTE, 1'b0);
         if ($urandom_range(0, 9) == 0) begin
            send_item(plain_byte(), 1'b0);
         end
      end
   endtask

   task automatic send_stream();
      int unsigned hdr_n;
      int unsigned lines;
      int unsigned ln;
      int unsigned nf;
      int unsigned pick;
      hdr_n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
      lines = $urandom_range(1, 8);
      for (ln = 0; ln <= lines; ln++) begin
         pick = $urandom_range(0, 99);
         if (pick >= 8 && pick < 18) begin
            repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick >= 18) begin
            nf = (ln == 0 || pick < 75) ? hdr_n : $urandom_range(1, 8);
            send_field();
            repeat (nf - 1) begin
               send_item(tk_delim, 1'b0);
               send_field();
            end
         end
         if (ln == lines && $urandom_range(0, 2) == 0) begin
            break;
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_item(csvt_pkg::CH_LF, 1'b0);
         end else if (pick < 9) begin
            send_item(csvt_pkg::CH_CR, 1'b0);
            send_item(csvt_pkg::CH_LF, 1'b0);
         end else begin
            send_item(csvt_pkg::CH_CR, 1'b0);
            send_item(csvt_pkg::CH_CR, 1'b0);
            send_item(csvt_pkg::CH_LF, 1'b0);
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic test_random_streams();
      int unsigned start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 9))
               0, 1:    write_delimiter(csvt_pkg::DELIM_RESET);
               2:       write_delimiter(8'h00);
               3:       write_delimiter(8'hFF);
               4:       write_delimiter(8'h09);
               5:       write_delimiter(8'h3B);
               6:       write_delimiter(csvt_pkg::CH_CR);
               7:       write_delimiter(csvt_pkg::CH_QUOTE);
               8:       write_delimiter(csvt_pkg::CH_LF);
               default: write_delimiter(8'($urandom_range(0, 255)));
            endcase
         end
         send_stream();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_valid        <= 1'b0;
      csr_delimiter    <= 8'h00;
      req_valid        <= 1'b0;
      req_data_byte    <= 8'h00;
      req_end_of_input <= 1'b0;
      tk_delim        = csvt_pkg::DELIM_RESET;
      clear_stream();
      items_sent      = 0;
      results_checked = 0;
      mismatch_count  = 0;
      burst_left      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_delimiter_values();
      test_column_saturation();
      test_random_streams();

      wait_drained();
      if (mismatch_count == 0) begin
         $display("csv_byte_tokenizer test passed");
      end else begin
         $display("csv_byte_tokenizer test failed");
      end
      $finish;
   end

endmodule

// ===== csv_byte_tokenizer.f =====
sv/csvt_pkg.sv
sv/csvt_front.sv
sv/csvt_queue.sv
sv/csvt_back.sv
sv/csv_byte_tokenizer.sv
bench/testbench.sv
